>>> hw/rtl/gcd_pkg.sv
package gcd_pkg;

   localparam int NUM_SLOTS = 6;
   localparam int VALUE_W   = 16;
   localparam int COUNT_W   = 16;
   localparam int SLOT_W    = 3;
   localparam int CSR_IDX_W = 3;

   typedef enum logic {
      OP_CHANGE    = 1'b0,
      OP_SET_STOCK = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIMITED_MODE = 3'd0,
      CSR_DENOM_0      = 3'd1,
      CSR_DENOM_1      = 3'd2,
      CSR_DENOM_2      = 3'd3,
      CSR_DENOM_3      = 3'd4,
      CSR_DENOM_4      = 3'd5,
      CSR_DENOM_5      = 3'd6
   } csr_index_type;

   localparam logic [VALUE_W-1:0] DENOM_RESET [NUM_SLOTS] =
      '{16'd500, 16'd200, 16'd100, 16'd50, 16'd10, 16'd1};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_DIV,
      ST_CLAMP,
      ST_MUL,
      ST_SUB,
      ST_EVAL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic stock_write;
      logic div_init;
      logic div_step;
      logic clamp;
      logic mul;
      logic sub;
      logic next_slot;
      logic eval;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic op_set;
      logic skip;
      logic last_slot;
      logic div_last;
   } sts_type;

endpackage

>>> hw/rtl/gcd_ifs.sv
interface gcd_req_if import gcd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [VALUE_W-1:0] amount;
   logic [SLOT_W-1:0]  slot;
   logic [VALUE_W-1:0] stock_value;

   modport source (output valid, operation, amount, slot, stock_value, input ready);
   modport sink   (input valid, operation, amount, slot, stock_value, output ready);
endinterface

interface gcd_rsp_if import gcd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               ok;
   logic [COUNT_W-1:0] count_0;
   logic [COUNT_W-1:0] count_1;
   logic [COUNT_W-1:0] count_2;
   logic [COUNT_W-1:0] count_3;
   logic [COUNT_W-1:0] count_4;
   logic [COUNT_W-1:0] count_5;

   modport source (output valid, ok, count_0, count_1, count_2, count_3, count_4, count_5,
                   input ready);
   modport sink   (input valid, ok, count_0, count_1, count_2, count_3, count_4, count_5,
                   output ready);
endinterface

interface gcd_csr_if import gcd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [VALUE_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/greedy_change_dispenser.sv
// Greedy change dispenser. A request either sets the coin stock of one slot or asks for
// change: the slots are walked in order, each taking as many coins as fit in the remaining
// amount (capped by the stock when limited_mode is set); the result carries ok and the count
// per slot, all zero if the amount cannot be met, in which case the stock is not touched.
// One request is worked at a time, and the next is taken while the previous result still
// waits in the output register. A set-stock request passes the START and DONE states. A
// change request passes START, then for each of the NUM_DENOMS slots SCAN, the divider steps,
// CLAMP, MUL and SUB, where a slot with zero face value or reached with nothing left is passed
// over in SCAN, and then EVAL and DONE; the amount is min(AMOUNT_WIDTH,16) bits wide.
// The divider is a serial restoring divider, which forms one quotient bit per cycle.
// Configuration writes are always ready and are meant for times when no request is in flight.
module greedy_change_dispenser import gcd_pkg::*; #(
   parameter int NUM_DENOMS   = 6,
   parameter int AMOUNT_WIDTH = 16
) (
   input  logic  clock,
   input  logic  reset,
   gcd_req_if.sink   req,
   gcd_rsp_if.source rsp,
   gcd_csr_if.sink   csr
);

   cmd_type                           cmd;
   sts_type                           sts;
   logic [NUM_SLOTS-1:0][COUNT_W-1:0] count;

   assign csr.ready = 1'b1;

   gcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gcd_datapath #(
      .NUM_DENOMS   (NUM_DENOMS),
      .AMOUNT_WIDTH (AMOUNT_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr.valid),
      .csr_index       (csr.index),
      .csr_data        (csr.data),
      .req_operation   (req.operation),
      .req_amount      (req.amount),
      .req_slot        (req.slot),
      .req_stock_value (req.stock_value),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_ok          (rsp.ok),
      .rsp_count       (count)
   );

   assign rsp.count_0 = count[0];
   assign rsp.count_1 = count[1];
   assign rsp.count_2 = count[2];
   assign rsp.count_3 = count[3];
   assign rsp.count_4 = count[4];
   assign rsp.count_5 = count[5];

endmodule

>>> hw/rtl/gcd_ctrl.sv
module gcd_ctrl import gcd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_START;
         end
         ST_START: begin
            state_in = sts.op_set ? ST_DONE : ST_SCAN;
         end
         ST_SCAN: begin
            if (!sts.skip) state_in = ST_DIV;
            else if (sts.last_slot) state_in = ST_EVAL;
         end
         ST_DIV: begin
            if (sts.div_last) state_in = ST_CLAMP;
         end
         ST_CLAMP: state_in = ST_MUL;
         ST_MUL:   state_in = ST_SUB;
         ST_SUB: begin
            state_in = sts.last_slot ? ST_EVAL : ST_SCAN;
         end
         ST_EVAL:  state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_START: begin
            cmd.stock_write = sts.op_set;
         end
         ST_SCAN: begin
            cmd.div_init  = !sts.skip;
            cmd.next_slot = sts.skip;
         end
         ST_DIV:   cmd.div_step = 1'b1;
         ST_CLAMP: cmd.clamp    = 1'b1;
         ST_MUL:   cmd.mul      = 1'b1;
         ST_SUB: begin
            cmd.sub       = 1'b1;
            cmd.next_slot = 1'b1;
         end
         ST_EVAL:  cmd.eval     = 1'b1;
         ST_DONE:  cmd.load_rsp = rsp_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/gcd_datapath.sv
module gcd_datapath import gcd_pkg::*; #(
   parameter int NUM_DENOMS   = 6,
   parameter int AMOUNT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [CSR_IDX_W-1:0]              csr_index,
   input  logic [VALUE_W-1:0]                csr_data,
   input  logic                              req_operation,
   input  logic [VALUE_W-1:0]                req_amount,
   input  logic [SLOT_W-1:0]                 req_slot,
   input  logic [VALUE_W-1:0]                req_stock_value,
   input  cmd_type                           cmd,
   output sts_type                           sts,
   output logic                              rsp_ok,
   output logic [NUM_SLOTS-1:0][COUNT_W-1:0] rsp_count
);

   localparam int AMT_W  = (AMOUNT_WIDTH < VALUE_W) ? AMOUNT_WIDTH : VALUE_W;
   localparam int DCNT_W = $clog2(AMT_W);
   localparam int SIDX_W = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;

   // configuration
   logic                limited_ff, limited_in;
   logic [VALUE_W-1:0]  denom_ff [NUM_SLOTS];
   logic [VALUE_W-1:0]  denom_in [NUM_SLOTS];
   logic [VALUE_W-1:0]  stock_ff [NUM_DENOMS];
   logic [VALUE_W-1:0]  stock_in [NUM_DENOMS];

   // request and scan state
   op_type                           op_ff, op_in;
   logic [SLOT_W-1:0]                slot_ff, slot_in;
   logic [VALUE_W-1:0]               stock_val_ff, stock_val_in;
   logic [AMT_W-1:0]                 rem_ff, rem_in;
   logic [SLOT_W-1:0]                k_ff, k_in;
   logic [AMT_W-1:0]                 dvd_ff, dvd_in;
   logic [VALUE_W-1:0]               part_ff, part_in;
   logic [DCNT_W-1:0]                dcnt_ff, dcnt_in;
   logic [COUNT_W-1:0]               cnt_ff, cnt_in;
   logic [2*VALUE_W-1:0]             prod_ff, prod_in;
   logic [NUM_SLOTS-1:0][COUNT_W-1:0] taken_ff, taken_in;
   logic                             ok_ff, ok_in;
   logic                             rsp_ok_ff, rsp_ok_in;
   logic [NUM_SLOTS-1:0][COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic [VALUE_W-1:0] denom_cur;
   logic [VALUE_W-1:0] stock_cur;
   logic [VALUE_W:0]   shifted;
   logic [VALUE_W:0]   diff;
   logic               fits;
   logic [COUNT_W-1:0] quot;
   logic [COUNT_W-1:0] clamp_val;
   logic               slot_ok;

   assign denom_cur = denom_ff[k_ff];
   assign stock_cur = stock_ff[k_ff[SIDX_W-1:0]];
   assign shifted   = {part_ff, dvd_ff[AMT_W-1]};
   assign diff      = shifted - {1'b0, denom_cur};
   assign fits      = shifted >= {1'b0, denom_cur};
   assign quot      = COUNT_W'(dvd_ff);
   assign clamp_val = (limited_ff && (quot > stock_cur)) ? stock_cur : quot;
   assign slot_ok   = slot_ff < SLOT_W'(NUM_DENOMS);

   assign sts.op_set    = (op_ff == OP_SET_STOCK);
   assign sts.skip      = (denom_cur == '0) || (rem_ff == '0);
   assign sts.last_slot = (k_ff == SLOT_W'(NUM_DENOMS - 1));
   assign sts.div_last  = (dcnt_ff == DCNT_W'(AMT_W - 1));

   // register writes
   always_comb begin
      limited_in = limited_ff;
      denom_in   = denom_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_LIMITED_MODE: limited_in  = csr_data[0];
            CSR_DENOM_0:      denom_in[0] = csr_data;
            CSR_DENOM_1:      denom_in[1] = csr_data;
            CSR_DENOM_2:      denom_in[2] = csr_data;
            CSR_DENOM_3:      denom_in[3] = csr_data;
            CSR_DENOM_4:      denom_in[4] = csr_data;
            CSR_DENOM_5:      denom_in[5] = csr_data;
            default:          limited_in  = limited_ff;
         endcase
      end
   end

   always_comb begin
      op_in        = op_ff;
      slot_in      = slot_ff;
      stock_val_in = stock_val_ff;
      rem_in       = rem_ff;
      k_in         = k_ff;
      dvd_in       = dvd_ff;
      part_in      = part_ff;
      dcnt_in      = dcnt_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      taken_in     = taken_ff;
      ok_in        = ok_ff;
      stock_in     = stock_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      if (cmd.load) begin
         op_in        = op_type'(req_operation);
         slot_in      = req_slot;
         stock_val_in = req_stock_value;
         rem_in       = req_amount[AMT_W-1:0];
         k_in         = '0;
         taken_in     = '0;
         ok_in        = 1'b0;
      end
      if (cmd.stock_write) begin
         ok_in = slot_ok;
         if (slot_ok) stock_in[slot_ff[SIDX_W-1:0]] = stock_val_ff;
      end
      if (cmd.div_init) begin
         dvd_in  = rem_ff;
         part_in = '0;
         dcnt_in = '0;
      end
      // restoring divider, one quotient bit per cycle
      if (cmd.div_step) begin
         dvd_in  = {dvd_ff[AMT_W-2:0], fits};
         part_in = fits ? diff[VALUE_W-1:0] : shifted[VALUE_W-1:0];
         dcnt_in = dcnt_ff + 1'b1;
      end
      if (cmd.clamp) begin
         cnt_in         = clamp_val;
         taken_in[k_ff] = clamp_val;
      end
      if (cmd.mul) prod_in = cnt_ff * denom_cur;
      if (cmd.sub) rem_in = rem_ff - prod_ff[AMT_W-1:0];
      if (cmd.next_slot && !sts.last_slot) k_in = k_ff + 1'b1;
      if (cmd.eval) begin
         ok_in = (rem_ff == '0);
         if (rem_ff != '0) begin
            taken_in = '0;
         end else if (limited_ff) begin
            for (int i = 0; i < NUM_DENOMS; i++) begin
               stock_in[i] = stock_ff[i] - taken_ff[i];
            end
         end
      end
      if (cmd.load_rsp) begin
         rsp_ok_in  = ok_ff;
         rsp_cnt_in = taken_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limited_ff <= 1'b1;
         denom_ff   <= DENOM_RESET;
         for (int i = 0; i < NUM_DENOMS; i++) begin
            stock_ff[i] <= '0;
         end
      end else begin
         limited_ff <= limited_in;
         denom_ff   <= denom_in;
         stock_ff   <= stock_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      slot_ff      <= slot_in;
      stock_val_ff <= stock_val_in;
      rem_ff       <= rem_in;
      k_ff         <= k_in;
      dvd_ff       <= dvd_in;
      part_ff      <= part_in;
      dcnt_ff      <= dcnt_in;
      cnt_ff       <= cnt_in;
      prod_ff      <= prod_in;
      taken_ff     <= taken_in;
      ok_ff        <= ok_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

   assign rsp_ok    = rsp_ok_ff;
   assign rsp_count = rsp_cnt_ff;

endmodule

>>> hw/rtl/gcd_checker.sv
module gcd_checker import gcd_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_ok,
   input logic [COUNT_W-1:0] rsp_count_0,
   input logic [COUNT_W-1:0] rsp_count_1,
   input logic [COUNT_W-1:0] rsp_count_2,
   input logic [COUNT_W-1:0] rsp_count_3,
   input logic [COUNT_W-1:0] rsp_count_4,
   input logic [COUNT_W-1:0] rsp_count_5
);

   logic [COUNT_W-1:0] any_count;

   assign any_count = rsp_count_0 | rsp_count_1 | rsp_count_2 |
                      rsp_count_3 | rsp_count_4 | rsp_count_5;

   // one request in flight: no new request right after one is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous one still in work");

   // a failed response, change or set-stock, reports no coins
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (any_count == '0))
      else $error("failed response carries nonzero counts");

   // a fresh response only appears at the end of work, never from idle
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid && !rsp_ready) && $past(reset) == 1'b0)
         |-> !$past(req_ready))
      else $error("response appeared without work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_ok) && $stable(any_count)))
      else $error("stalled response changed");

endmodule

bind greedy_change_dispenser gcd_checker u_gcd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_ok      (rsp.ok),
   .rsp_count_0 (rsp.count_0),
   .rsp_count_1 (rsp.count_1),
   .rsp_count_2 (rsp.count_2),
   .rsp_count_3 (rsp.count_3),
   .rsp_count_4 (rsp.count_4),
   .rsp_count_5 (rsp.count_5)
);

>>> dv/change_checker.sv
module change_checker import gcd_pkg::*; (
   input  logic clock,
   input  logic reset,
   gcd_req_if   req_mon,
   gcd_rsp_if   rsp_mon,
   gcd_csr_if   csr_mon,
   output int   errors,
   output int   pending,
   output int   checked
);

   localparam int unsigned COUNT_CAP = 65535;

   typedef struct packed {
      logic                              ok;
      logic [NUM_SLOTS-1:0][COUNT_W-1:0] count;
   } result_type;

   // mirror of the registers and the coin stock
   logic               limited_on;
   logic [VALUE_W-1:0] face [NUM_SLOTS];
   logic [COUNT_W-1:0] stock [NUM_SLOTS];

   result_type         change_q [$];
   result_type         want, got;
   int                 err_cnt;
   int                 n_checked;

   initial begin
      err_cnt   = 0;
      n_checked = 0;
   end

   function automatic result_type dispense(op_type op, logic [VALUE_W-1:0] amt,
                                           logic [SLOT_W-1:0] slot_sel,
                                           logic [VALUE_W-1:0] new_stock);
      result_type         res;
      int unsigned        left;
      int unsigned        coins;
      int                 k;
      logic [COUNT_W-1:0] take [NUM_SLOTS];
      res = '0;
      if (op == OP_SET_STOCK) begin
         if (slot_sel < NUM_SLOTS) begin
            stock[slot_sel] = new_stock;
            res.ok = 1'b1;
         end
         return res;
      end
      left = amt;
      for (k = 0; k < NUM_SLOTS; k++) begin
         take[k] = '0;
         if (face[k] == 0 || left == 0)
            continue;
         coins = left / face[k];
         if (coins > COUNT_CAP)
            coins = COUNT_CAP;
         if (limited_on && coins > stock[k])
            coins = stock[k];
         take[k] = coins[COUNT_W-1:0];
         left -= coins * face[k];
      end
      // amount not met: all counts zero, stock untouched
      if (left != 0)
         return res;
      if (limited_on) begin
         for (k = 0; k < NUM_SLOTS; k++)
            stock[k] -= take[k];
      end
      res.ok = 1'b1;
      for (k = 0; k < NUM_SLOTS; k++)
         res.count[k] = take[k];
      return res;
   endfunction

   task automatic report(string field, int exp_val, int act_val);
      err_cnt++;
      $display("%0t: mismatch on %s, expected %0d, actual %0d",
               $time, field, exp_val, act_val);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         limited_on = 1'b1;
         face       = DENOM_RESET;
         for (int k = 0; k < NUM_SLOTS; k++)
            stock[k] = '0;
         change_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_LIMITED_MODE: limited_on = csr_mon.data[0];
               CSR_DENOM_0, CSR_DENOM_1, CSR_DENOM_2,
               CSR_DENOM_3, CSR_DENOM_4, CSR_DENOM_5:
                  face[csr_mon.index - CSR_DENOM_0] = csr_mon.data;
               default: ;
            endcase
         end
         // results leave before a new request enters, so a result can never
         // pair with the request taken at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.ok       = rsp_mon.ok;
            got.count[0] = rsp_mon.count_0;
            got.count[1] = rsp_mon.count_1;
            got.count[2] = rsp_mon.count_2;
            got.count[3] = rsp_mon.count_3;
            got.count[4] = rsp_mon.count_4;
            got.count[5] = rsp_mon.count_5;
            if (change_q.size() == 0) begin
               report("unexpected result, ok", -1, got.ok);
            end else begin
               want = change_q.pop_front();
               n_checked++;
               if (want.ok !== got.ok)
                  report("ok", want.ok, got.ok);
               for (int k = 0; k < NUM_SLOTS; k++) begin
                  if (want.count[k] !== got.count[k])
                     report($sformatf("count_%0d", k), want.count[k], got.count[k]);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            change_q.push_back(dispense(op_type'(req_mon.operation), req_mon.amount,
                                        req_mon.slot, req_mon.stock_value));
      end
      pending <= change_q.size();
      errors  <= err_cnt;
      checked <= n_checked;
   end

endmodule

>>> dv/testbench.sv
module testbench;
   import gcd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int HOLD_CYCLES       = 400;
   localparam int ITEMS_PER_SETTING = 235;
   localparam int DRAIN_CYCLES      = 150;

   logic               clock;
   logic               reset;
   int                 errors;
   int                 pending;
   int                 checked;
   bit                 quiet;
   bit                 hold_rsp;
   logic [VALUE_W-1:0] face_now [NUM_SLOTS];
   logic [VALUE_W-1:0] setting [NUM_SLOTS];
   int                 n_change;
   int                 n_stock;
   int                 n_settings;

   gcd_req_if req_ch ();
   gcd_rsp_if rsp_ch ();
   gcd_csr_if csr_ch ();

   greedy_change_dispenser dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   change_checker chk (
      .clock   (clock),
      .reset   (reset),
      .req_mon (req_ch),
      .rsp_mon (rsp_ch),
      .csr_mon (csr_ch),
      .errors  (errors),
      .pending (pending),
      .checked (checked)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #40_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      else if (pick < 85)
         return $urandom_range(1, 3);
      else if (pick < 97)
         return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   // result side: random back-pressure, a long hold-off when asked
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (quiet) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            gap = idle_len();
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // valid stays high after acceptance; the next call or drain decides
   task automatic send(op_type op, logic [VALUE_W-1:0] amt, logic [SLOT_W-1:0] slot_sel,
                       logic [VALUE_W-1:0] new_stock);
      int gap;
      gap = quiet ? 0 : idle_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= op;
      req_ch.amount      <= amt;
      req_ch.slot        <= slot_sel;
      req_ch.stock_value <= new_stock;
      do @(posedge clock); while (!req_ch.ready);
      if (op == OP_CHANGE)
         n_change++;
      else
         n_stock++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [VALUE_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic load_config(bit lim, bit poke_unused);
      int k;
      drain();
      if (poke_unused)
         csr_write(CSR_UNUSED, 16'hFFFF);
      // only bit 0 of the mode write matters
      csr_write(CSR_LIMITED_MODE, {15'($urandom_range(0, 32767)), lim});
      for (k = 0; k < NUM_SLOTS; k++)
         csr_write(CSR_IDX_W'(CSR_DENOM_0 + k), setting[k]);
      csr_ch.valid <= 1'b0;
      face_now = setting;
      n_settings++;
   endtask

   function automatic logic [VALUE_W-1:0] pick_amount();
      int unsigned sum;
      int unsigned part;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      if (pick <= 2)
         return VALUE_W'($urandom());
      if (pick <= 4)
         return VALUE_W'($urandom_range(0, 1000));
      // sum of a few coins of each face, so that most of these can be paid
      sum = 0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
         part = $urandom_range(0, 3) * face_now[k];
         if (sum + part <= 65535)
            sum += part;
      end
      return VALUE_W'(sum);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_stock();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return VALUE_W'($urandom_range(0, 50));
      if (pick < 85)
         return VALUE_W'($urandom_range(0, 1000));
      if (pick < 95)
         return VALUE_W'($urandom());
      return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
   endfunction

   task automatic run_random(int items, int stock_pct);
      logic [SLOT_W-1:0] slot_sel;
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(0, 99) < stock_pct) begin
            slot_sel = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(6, 7))
                                                   : SLOT_W'($urandom_range(0, 5));
            send(OP_SET_STOCK, VALUE_W'($urandom()), slot_sel, pick_stock());
         end else begin
            send(OP_CHANGE, pick_amount(), SLOT_W'($urandom()), VALUE_W'($urandom()));
         end
      end
   endtask

   initial begin
      logic [VALUE_W-1:0] top_face;
      bit                 lim;
      req_ch.valid       <= 1'b0;
      req_ch.operation   <= OP_CHANGE;
      req_ch.amount      <= '0;
      req_ch.slot        <= '0;
      req_ch.stock_value <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= CSR_LIMITED_MODE;
      csr_ch.data        <= '0;
      reset              <= 1'b1;
      quiet      = 1'b0;
      hold_rsp   = 1'b0;
      n_change   = 0;
      n_stock    = 0;
      n_settings = 0;
      face_now   = DENOM_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, stock empty
      send(OP_CHANGE, 16'd0, 3'd0, 16'd0);
      send(OP_CHANGE, 16'hFFFF, 3'd0, 16'd0);
      send(OP_SET_STOCK, 16'd0, 3'd0, 16'hFFFF);
      send(OP_SET_STOCK, 16'd0, 3'd1, 16'd0);
      send(OP_SET_STOCK, 16'd0, 3'd2, 16'd2);
      send(OP_SET_STOCK, 16'd0, 3'd3, 16'd1);
      send(OP_SET_STOCK, 16'd0, 3'd4, 16'd7);
      send(OP_SET_STOCK, 16'hFFFF, 3'd5, 16'hFFFF);
      send(OP_SET_STOCK, 16'd0, 3'd6, 16'hFFFF);
      send(OP_SET_STOCK, 16'd0, 3'd7, 16'd0);
      send(OP_CHANGE, 16'd1, 3'd7, 16'hFFFF);
      send(OP_CHANGE, 16'hFFFF, 3'd0, 16'd0);
      send(OP_CHANGE, 16'd888, 3'd0, 16'd0);
      send(OP_CHANGE, 16'd40000, 3'd0, 16'd0);

      // unlimited, with a zero face value in slot 1
      setting = '{16'd500, 16'd0, 16'd100, 16'd50, 16'd10, 16'd1};
      load_config(1'b0, 1'b1);
      send(OP_CHANGE, 16'hFFFF, 3'd0, 16'd0);
      send(OP_CHANGE, 16'd350, 3'd0, 16'd0);
      send(OP_CHANGE, 16'd0, 3'd0, 16'd0);
      send(OP_SET_STOCK, 16'd0, 3'd3, 16'd12);

      // only unit coins: count reaches its maximum
      setting = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1};
      load_config(1'b0, 1'b0);
      send(OP_CHANGE, 16'hFFFF, 3'd0, 16'd0);
      send(OP_CHANGE, 16'd7, 3'd0, 16'd0);

      // no usable face at all
      setting = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
      load_config(1'b1, 1'b0);
      send(OP_CHANGE, 16'd5, 3'd0, 16'd0);
      send(OP_CHANGE, 16'd0, 3'd0, 16'd0);

      for (int p = 0; p < 8; p++) begin
         lim = 1'b1;
         case (p)
            0: setting = DENOM_RESET;
            1: begin
               setting = DENOM_RESET;
               lim = 1'b0;
            end
            2: setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            3: begin
               setting = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
               lim = 1'b0;
            end
            4: begin
               top_face = VALUE_W'($urandom_range(2000, 65535));
               for (int k = 0; k < NUM_SLOTS; k++) begin
                  setting[k] = top_face;
                  top_face = VALUE_W'($urandom_range(1, top_face));
               end
            end
            5: begin
               for (int k = 0; k < NUM_SLOTS; k++)
                  setting[k] = ($urandom_range(0, 1) != 0) ? VALUE_W'($urandom_range(1, 65535))
                                                           : VALUE_W'($urandom_range(1, 300));
            end
            6: begin
               setting = '{16'd250, 16'd0, 16'd75, 16'd20, 16'd0, 16'd3};
               lim = 1'b0;
            end
            default: setting = '{16'd3, 16'd25, 16'd10, 16'd7, 16'd5, 16'd1};
         endcase
         load_config(lim, p == 6);
         if (p == 4) begin
            // no idling either side, then a long result stall so the block backs up
            quiet = 1'b1;
            run_random(20, 30);
            hold_rsp = 1'b1;
            run_random(ITEMS_PER_SETTING - 20, 30);
            quiet = 1'b0;
         end else begin
            run_random(ITEMS_PER_SETTING, lim ? 30 : 10);
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d change and %0d set-stock requests across %0d register settings",
               n_change, n_stock, n_settings);
      $display("%0d results compared, %0d mismatches", checked, errors);
      if (errors == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/gcd_pkg.sv
hw/rtl/gcd_ifs.sv
hw/rtl/gcd_ctrl.sv
hw/rtl/gcd_datapath.sv
hw/rtl/greedy_change_dispenser.sv
hw/rtl/gcd_checker.sv
dv/change_checker.sv
dv/testbench.sv
